@@ rtl/scalar_minmax_clamp_convert_unit_core_macros.svh @@
// Assertion macros for the scalar min/max/clamp/convert unit.
// Included by the top level; no other dependencies.
`ifndef SCALAR_MINMAX_CLAMP_CONVERT_UNIT_CORE_MACROS_SVH
`define SCALAR_MINMAX_CLAMP_CONVERT_UNIT_CORE_MACROS_SVH

// Implication checked on every edge outside reset.
`define SMC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/smcc_pkg.sv @@
// Package for the scalar min/max/clamp/convert unit: action and status codes,
// float helpers. No dependencies.
`default_nettype none
package smcc_pkg;

    typedef logic [3:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_ABSI   = 4'd0;
    localparam action_t ACT_ABSF   = 4'd1;
    localparam action_t ACT_MINI   = 4'd2;
    localparam action_t ACT_MAXI   = 4'd3;
    localparam action_t ACT_MINF   = 4'd4;
    localparam action_t ACT_MAXF   = 4'd5;
    localparam action_t ACT_CLAMPI = 4'd6;
    localparam action_t ACT_CLAMPF = 4'd7;
    localparam action_t ACT_FLOOR  = 4'd8;
    localparam action_t ACT_CEIL   = 4'd9;
    localparam action_t ACT_ROUND  = 4'd10;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_ORDER = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] F_INT32_MIN = 32'hCF00_0000;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // signed int32 a < b
    function automatic logic int_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // IEEE single a < b, C semantics (NaN false, -0 == +0)
    function automatic logic flt_less(input logic [31:0] a, input logic [31:0] b);
        logic both_zero;
        logic res;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b) || both_zero)
            res = 1'b0;
        else if (a[31] != b[31])
            res = a[31];
        else if (!a[31])
            res = a[30:0] < b[30:0];
        else
            res = a[30:0] > b[30:0];
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/scalar_minmax_clamp_convert_unit_core.sv @@
// Top level of the scalar min/max/clamp/convert unit.
// Depends on smcc_pkg and scalar_minmax_clamp_convert_unit_core_macros.svh.
//
//   channel | ports                                             | dir
//   in      | in_valid/in_ready, action, first/second/third_op. | in
//   out     | out_valid/out_ready, value, status                | out
//
// One item per cycle unless the output stalls: input register, one combinational pass, result register.
// The result passes the input register, then the result register (two register stages).
// Reset clears the valid bits only.
// The input register loads whenever it is empty or the result register is free or drains
// in the same cycle; a stalled output holds the result, and the input register once full.
`default_nettype none
`include "scalar_minmax_clamp_convert_unit_core_macros.svh"
module scalar_minmax_clamp_convert_unit_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] first_operand,
    input  wire logic [31:0] second_operand,
    input  wire logic [31:0] third_operand,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      value,
    output logic [1:0]       status
);

    logic              s1_valid_reg;
    smcc_pkg::action_t s1_act_reg;
    logic [31:0]       s1_a_reg, s1_b_reg, s1_c_reg;
    logic              out_valid_reg;
    logic [31:0]       value_reg, value_next;
    smcc_pkg::status_t status_reg, status_next;
    logic              out_load, s1_load;

    assign out_load = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_load;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_act_reg <= action;
            s1_a_reg   <= first_operand;
            s1_b_reg   <= second_operand;
            s1_c_reg   <= third_operand;
        end
        if (out_load && s1_valid_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    // float to int conversion
    logic [7:0]  cv_e, cv_eff;
    logic [23:0] cv_mant;
    logic        cv_neg, cv_fnz, cv_half, cv_inc;
    logic [31:0] cv_mag, cv_res;
    logic [7:0]  cv_sh;
    logic [55:0] cv_wide;
    smcc_pkg::status_t cv_st;

    always_comb
    begin
        cv_e    = s1_a_reg[30:23];
        cv_neg  = s1_a_reg[31];
        cv_mant = {(cv_e != 8'd0), s1_a_reg[22:0]};
        cv_eff  = (cv_e == 8'd0) ? 8'd1 : cv_e;
        cv_mag  = 32'd0;
        cv_fnz  = 1'b0;
        cv_half = 1'b0;
        cv_inc  = 1'b0;
        cv_sh   = 8'd0;
        cv_wide = 56'd0;
        cv_st   = smcc_pkg::ST_OK;
        cv_res  = 32'd0;
        if (cv_e == 8'hFF)
            cv_st = smcc_pkg::ST_RANGE;
        else if (cv_e >= 8'd158)
        begin
            if (s1_a_reg == smcc_pkg::F_INT32_MIN)
                cv_res = smcc_pkg::SIGN_BIT;
            else
                cv_st = smcc_pkg::ST_RANGE;
        end
        else if (cv_eff >= 8'd150)
        begin
            cv_sh  = cv_eff - 8'd150;
            cv_mag = {8'd0, cv_mant} << cv_sh[2:0];
            cv_res = cv_neg ? (32'd0 - cv_mag) : cv_mag;
        end
        else
        begin
            // shift mantissa right by 150-e, keep 32 fraction bits below
            cv_sh = 8'd150 - cv_eff;
            if (cv_sh <= 8'd32)
                cv_wide = {cv_mant, 32'd0} >> cv_sh[5:0];
            cv_mag  = {8'd0, cv_wide[55:32]};
            cv_half = (cv_sh <= 8'd32) ? cv_wide[31] : 1'b0;
            cv_fnz  = (cv_sh <= 8'd32) ? (cv_wide[31:0] != 32'd0) : (cv_mant != 24'd0);
            unique case (s1_act_reg)
                smcc_pkg::ACT_ROUND: cv_inc = cv_half;
                smcc_pkg::ACT_FLOOR: cv_inc = cv_neg && cv_fnz;
                default:             cv_inc = !cv_neg && cv_fnz;
            endcase
            cv_mag = cv_mag + {31'd0, cv_inc};
            cv_res = cv_neg ? (32'd0 - cv_mag) : cv_mag;
        end
    end

    logic [31:0] a, b, c;
    assign a = s1_a_reg;
    assign b = s1_b_reg;
    assign c = s1_c_reg;

    always_comb
    begin
        value_next  = 32'd0;
        status_next = smcc_pkg::ST_OK;
        unique case (s1_act_reg)
            smcc_pkg::ACT_ABSI:
                if (a == smcc_pkg::SIGN_BIT)
                    status_next = smcc_pkg::ST_RANGE;
                else
                    value_next = a[31] ? (32'd0 - a) : a;
            smcc_pkg::ACT_ABSF: value_next = {1'b0, a[30:0]};
            smcc_pkg::ACT_MINI: value_next = smcc_pkg::int_less(a, b) ? a : b;
            smcc_pkg::ACT_MAXI: value_next = smcc_pkg::int_less(b, a) ? a : b;
            smcc_pkg::ACT_MINF: value_next = smcc_pkg::flt_less(a, b) ? a : b;
            smcc_pkg::ACT_MAXF: value_next = smcc_pkg::flt_less(b, a) ? a : b;
            smcc_pkg::ACT_CLAMPI:
                if (smcc_pkg::int_less(c, b))
                    status_next = smcc_pkg::ST_ORDER;
                else
                    value_next = smcc_pkg::int_less(a, b) ? b :
                                 (smcc_pkg::int_less(c, a) ? c : a);
            smcc_pkg::ACT_CLAMPF:
                if (smcc_pkg::flt_less(c, b))
                    status_next = smcc_pkg::ST_ORDER;
                else
                    value_next = smcc_pkg::flt_less(a, b) ? b :
                                 (smcc_pkg::flt_less(c, a) ? c : a);
            smcc_pkg::ACT_FLOOR, smcc_pkg::ACT_CEIL, smcc_pkg::ACT_ROUND:
            begin
                status_next = cv_st;
                value_next  = (cv_st == smcc_pkg::ST_OK) ? cv_res : 32'd0;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    `SMC_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (status != smcc_pkg::ST_OK), value == 32'd0, "error result with nonzero value")
    `SMC_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, status != 2'd3, "bad status code")
    `SMC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(status), "result changed while stalled")

endmodule
`default_nettype wire
